// ===== hdl/lsais_pkg.sv =====
// Shared types and constants for the superblock arc interval scan.
`timescale 1ns / 1ps
package lsais_pkg;

  localparam int unsigned LEN_W  = 12;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned OVL_W  = 13;
  localparam int unsigned SYM_W  = 3;
  localparam int unsigned CFG_AW = 8;

  // Register indexes of the configuration port
  localparam logic [CFG_AW-1:0] REG_FULL_READ_LEN = 8'd0;
  localparam logic [CFG_AW-1:0] REG_MIN_OVERLAP   = 8'd1;
  localparam logic [CFG_AW-1:0] REG_BUCKET_A      = 8'd2;
  localparam logic [CFG_AW-1:0] REG_BUCKET_C      = 8'd3;
  localparam logic [CFG_AW-1:0] REG_BUCKET_G      = 8'd4;
  localparam logic [CFG_AW-1:0] REG_BUCKET_T      = 8'd5;

  // One stack entry: a closed superblock
  typedef struct packed {
    logic [CNT_W-1:0] reads;
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] stop;
    logic [CNT_W-1:0] start;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Work handed from the front to the back for one record
  typedef struct packed {
    logic             push;
    logic             last;
    logic [LEN_W-1:0] lcur;
    logic [CNT_W-1:0] reads_old;
    logic [CNT_W-1:0] reads_new;
    logic [SYM_W-1:0] lead;
    entry_t           ent;
  } cmd_t;

  // One emitted arc interval
  typedef struct packed {
    logic             run_last;
    logic             overflow;
    logic [SYM_W-1:0] lead;
    logic [OVL_W-1:0] overlap;
    logic [CNT_W-1:0] seed_count;
    logic [CNT_W-1:0] seed_first;
    logic [CNT_W-1:0] range_end;
    logic [CNT_W-1:0] range_begin;
  } result_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PUSH,
    B_READ,
    B_CHECK,
    B_DONE
  } back_state_e;

endpackage

// ===== hdl/lcp_superblock_arc_interval_scan.sv =====
// Top level of the LCP superblock arc interval scan.
// Usage: write the six registers on the cfg channel (index 0..5) while idle;
// cfg_ready_o is always high. Stream suffix-array records in sorted order on
// s_axis; tlast marks the final record of a stream and tuser its BWT marker.
// Each record may emit zero or more arc intervals on m_axis; tlast marks the
// last interval caused by one record, tuser carries the sticky overflow flag.
// Flow: the front classifies a record in its accept cycle and queues it
// (two entries). The back steps each record through idle, a push when the
// record closes a pending block, a read of the registered-read stack RAM and
// a check (repeated per popped stack entry), a further check to switch into
// the drain on a final record, and done. A found result waits in a one-entry
// hold slot until the next result or the end of its record, then moves into
// the output register.
// Reset empties the queue, the stack fill count and the output; stack RAM
// contents are not cleared. When m_axis stalls and the hold slot and output
// register are both full, the back holds any pop that yields a result and
// its done step; the front keeps accepting until the queue fills.
`timescale 1ns / 1ps
module lcp_superblock_arc_interval_scan
  import lsais_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned POS_BITS    = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CNT_W-1:0]  cfg_data_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // suffix_len[11:0], lcp_here[23:12], lcp_ahead[35:24], zero[39:36]
  input  logic [39:0]       s_axis_tdata_i,
  // bwt_is_marker
  input  logic              s_axis_tuser_i,
  input  logic              s_axis_tlast_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // range_begin[31:0], range_end[63:32], seed_first[95:64],
  // seed_count[127:96], overlap_len[140:128], lead_symbol[143:141]
  output logic [143:0]      m_axis_tdata_o,
  // overflow_seen
  output logic              m_axis_tuser_o,
  output logic              m_axis_tlast_o
);

  cmd_t       cmd_in, cmd_q;
  logic       q_full, q_empty, q_pop, take;
  logic [1:0] q_count;
  result_t    res;
  logic [$clog2(STACK_DEPTH+1)-1:0] fill;
  logic       ovf;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !q_full;
  assign take            = s_axis_tvalid_i && !q_full;

  lsais_front #(.POS_BITS(POS_BITS)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .take_i          (take),
    .suffix_len_i    (s_axis_tdata_i[11:0]),
    .lcp_here_i      (s_axis_tdata_i[23:12]),
    .lcp_ahead_i     (s_axis_tdata_i[35:24]),
    .bwt_is_marker_i (s_axis_tuser_i),
    .final_record_i  (s_axis_tlast_i),
    .cmd_o           (cmd_in)
  );

  lsais_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .wdata_i (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (cmd_q),
    .count_o (q_count)
  );

  lsais_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (cmd_q),
    .cmd_pop_o   (q_pop),
    .res_o       (res),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .fill_o      (fill),
    .overflow_o  (ovf)
  );

  assign m_axis_tdata_o = {res.lead, res.overlap, res.seed_count, res.seed_first,
                           res.range_end, res.range_begin};
  assign m_axis_tuser_o = res.overflow;
  assign m_axis_tlast_o = res.run_last;

  // Stack never holds more than its depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill) <= STACK_DEPTH) else $error("stack fill beyond depth");

  // Overflow flag is sticky
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf |=> ovf) else $error("overflow flag cleared");

  // Queue never pops while empty
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_count != 2'd0) else $error("queue popped while empty");

endmodule

// ===== hdl/lsais_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module lsais_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/lsais_queue.sv =====
// Two-entry queue that decouples the front from the back.
`timescale 1ns / 1ps
module lsais_queue
  import lsais_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cmd_t       wdata_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output cmd_t       rdata_o,
  output logic [1:0] count_o
);

  cmd_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = slot_q[rp_q];
  assign count_o = cnt_q;

  // Store payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= wdata_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== hdl/lsais_front.sv =====
// Front: configuration, position and read counting, block opening.
`timescale 1ns / 1ps
module lsais_front
  import lsais_pkg::*;
#(
  parameter int unsigned POS_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CNT_W-1:0]  cfg_data_i,
  input  logic              take_i,
  input  logic [LEN_W-1:0]  suffix_len_i,
  input  logic [LEN_W-1:0]  lcp_here_i,
  input  logic [LEN_W-1:0]  lcp_ahead_i,
  input  logic              bwt_is_marker_i,
  input  logic              final_record_i,
  output cmd_t              cmd_o
);

  localparam int unsigned CW = (POS_BITS > CNT_W) ? POS_BITS : CNT_W;

  logic [LEN_W-1:0]    frl_q, tau_q;
  logic [CNT_W-1:0]    bkt_q [4];
  logic [POS_BITS-1:0] pos_q, pos_d, open_begin_q, open_begin_d;
  logic [CNT_W-1:0]    reads_q, reads_d, open_reads_q, open_reads_d;
  logic [LEN_W-1:0]    open_len_q, open_len_d;
  logic                opening_q, opening_d;

  logic [CW-1:0]    pos_w, begin_w;
  logic [3:0]       above;
  logic             push, rd_inc, open_now;
  logic [CNT_W-1:0] reads_new;
  logic [SYM_W-1:0] lead;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frl_q <= '0;
      tau_q <= '0;
      for (int i = 0; i < 4; i++) bkt_q[i] <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_FULL_READ_LEN: frl_q    <= cfg_data_i[LEN_W-1:0];
        REG_MIN_OVERLAP:   tau_q    <= cfg_data_i[LEN_W-1:0];
        REG_BUCKET_A:      bkt_q[0] <= cfg_data_i;
        REG_BUCKET_C:      bkt_q[1] <= cfg_data_i;
        REG_BUCKET_G:      bkt_q[2] <= cfg_data_i;
        REG_BUCKET_T:      bkt_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Bucket compares against the current position
  assign pos_w   = CW'(pos_q);
  assign begin_w = CW'(open_begin_q);
  always_comb begin
    for (int i = 0; i < 4; i++) above[i] = pos_w > CW'(bkt_q[i]);
  end
  always_comb begin
    if (!above[0])      lead = SYM_W'(0);
    else if (!above[1]) lead = SYM_W'(1);
    else if (!above[2]) lead = SYM_W'(2);
    else if (!above[3]) lead = SYM_W'(3);
    else                lead = SYM_W'(4);
  end

  // Classify the record
  assign push   = opening_q && (suffix_len_i != open_len_q || lcp_here_i != open_len_q);
  assign rd_inc = ((frl_q == '0) && bwt_is_marker_i) ||
                  ((suffix_len_i == frl_q) && (pos_w >= CW'(bkt_q[0])));
  assign reads_new = reads_q + CNT_W'(rd_inc);
  assign open_now  = (lcp_here_i < lcp_ahead_i) && (lcp_ahead_i >= tau_q) &&
                     (suffix_len_i == lcp_ahead_i);

  always_comb begin
    cmd_o.push      = push;
    cmd_o.last      = final_record_i;
    cmd_o.lcur      = lcp_here_i;
    cmd_o.reads_old = reads_q;
    cmd_o.reads_new = reads_new;
    cmd_o.lead      = lead;
    cmd_o.ent.start = begin_w[CNT_W-1:0];
    cmd_o.ent.stop  = pos_w[CNT_W-1:0];
    cmd_o.ent.len   = open_len_q;
    cmd_o.ent.reads = open_reads_q;
  end

  // Next scan state
  always_comb begin
    pos_d        = pos_q;
    reads_d      = reads_q;
    opening_d    = opening_q;
    open_begin_d = open_begin_q;
    open_len_d   = open_len_q;
    open_reads_d = open_reads_q;
    if (take_i) begin
      reads_d = reads_new;
      if (push) opening_d = 1'b0;
      if (open_now) begin
        opening_d    = 1'b1;
        open_begin_d = pos_q;
        open_len_d   = lcp_ahead_i;
        open_reads_d = reads_new;
      end
      if (final_record_i) begin
        pos_d     = '0;
        reads_d   = '0;
        opening_d = 1'b0;
      end else begin
        pos_d = pos_q + POS_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      reads_q      <= '0;
      opening_q    <= 1'b0;
      open_begin_q <= '0;
      open_len_q   <= '0;
      open_reads_q <= '0;
    end else begin
      pos_q        <= pos_d;
      reads_q      <= reads_d;
      opening_q    <= opening_d;
      open_begin_q <= open_begin_d;
      open_len_q   <= open_len_d;
      open_reads_q <= open_reads_d;
    end
  end

endmodule

// ===== hdl/lsais_back.sv =====
// Back: stack push, pop loop, drain, and the output register.
`timescale 1ns / 1ps
module lsais_back
  import lsais_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  input  cmd_t                             cmd_i,
  output logic                             cmd_pop_o,
  output result_t                          res_o,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output logic [$clog2(STACK_DEPTH+1)-1:0] fill_o,
  output logic                             overflow_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned FW = $clog2(STACK_DEPTH + 1);

  back_state_e state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          ovf_q, ovf_d, drain_q, drain_d;
  logic          hold_v_q, hold_v_d, out_v_q, out_v_d;
  result_t       hold_q, hold_d, out_q, out_d;

  logic [ENTRY_W-1:0] rdata;
  entry_t             top;
  logic               we, empty, do_pop, emit, out_free, stall;
  logic [CNT_W-1:0]   reads_ref;
  result_t            fresh;

  lsais_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (cmd_i.ent),
    .raddr_i (AW'(fill_q - FW'(1))),
    .rdata_o (rdata)
  );

  // Pop decision on the top entry
  assign top       = entry_t'(rdata);
  assign empty     = (fill_q == '0);
  assign do_pop    = !empty && (drain_q || top.len > cmd_i.lcur);
  assign reads_ref = drain_q ? cmd_i.reads_new : cmd_i.reads_old;
  assign emit      = do_pop && (top.reads < reads_ref);
  assign out_free  = !out_v_q || res_ready_i;
  assign stall     = hold_v_q && !out_free;
  assign we        = (state_q == B_PUSH) && (fill_q != FW'(STACK_DEPTH));

  always_comb begin
    fresh.range_begin = top.start;
    fresh.range_end   = top.stop;
    fresh.seed_first  = top.reads;
    fresh.seed_count  = reads_ref - top.reads;
    fresh.overlap     = OVL_W'(top.len) + OVL_W'(1);
    fresh.lead        = cmd_i.lead;
    fresh.overflow    = ovf_q;
    fresh.run_last    = 1'b0;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (cmd_valid_i) state_d = cmd_i.push ? B_PUSH : B_READ;
      B_PUSH:  state_d = B_READ;
      B_READ:  state_d = B_CHECK;
      B_CHECK: begin
        if (emit && stall)               state_d = B_CHECK;
        else if (do_pop)                 state_d = B_READ;
        else if (cmd_i.last && !drain_q) state_d = B_CHECK;
        else                             state_d = B_DONE;
      end
      B_DONE:  if (!stall) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    fill_d    = fill_q;
    ovf_d     = ovf_q;
    drain_d   = drain_q;
    hold_v_d  = hold_v_q;
    hold_d    = hold_q;
    out_v_d   = out_v_q && !res_ready_i;
    out_d     = out_q;
    cmd_pop_o = 1'b0;
    case (state_q)
      B_PUSH: begin
        if (we) fill_d = fill_q + FW'(1);
        else    ovf_d  = 1'b1;
      end
      B_CHECK: begin
        if (!(emit && stall)) begin
          if (do_pop) begin
            fill_d = fill_q - FW'(1);
            if (emit) begin
              if (hold_v_q) begin
                out_v_d = 1'b1;
                out_d   = hold_q;
              end
              hold_v_d = 1'b1;
              hold_d   = fresh;
            end
          end else if (cmd_i.last && !drain_q) begin
            drain_d = 1'b1;
          end
        end
      end
      B_DONE: begin
        if (!stall) begin
          if (hold_v_q) begin
            out_v_d          = 1'b1;
            out_d            = hold_q;
            out_d.run_last   = 1'b1;
            hold_v_d         = 1'b0;
          end
          drain_d   = 1'b0;
          cmd_pop_o = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      fill_q   <= '0;
      ovf_q    <= 1'b0;
      drain_q  <= 1'b0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      ovf_q    <= ovf_d;
      drain_q  <= drain_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  assign res_o       = out_q;
  assign res_valid_o = out_v_q;
  assign fill_o      = fill_q;
  assign overflow_o  = ovf_q;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the LCP superblock arc interval scan.
`timescale 1ns / 1ps
module tb_top;
  import lsais_pkg::*;

  localparam int unsigned STACK_N    = 64;
  localparam int unsigned CYCLE_CAP  = 600000;
  localparam int unsigned SETTLE_CYC = 300;
  // An index that maps to no register; writes to it must be ignored
  localparam logic [CFG_AW-1:0] REG_UNMAPPED = 8'd7;

  typedef struct {
    logic [LEN_W-1:0] slen;
    logic [LEN_W-1:0] lcur;
    logic [LEN_W-1:0] lnext;
    bit               marker;
    bit               is_last;
  } sa_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [CNT_W-1:0]  cfg_data_i = '0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [39:0]       s_axis_tdata_i = '0;
  logic              s_axis_tuser_i = 1'b0;
  logic              s_axis_tlast_i = 1'b0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [143:0]      m_axis_tdata_o;
  logic              m_axis_tuser_o;
  logic              m_axis_tlast_o;

  lcp_superblock_arc_interval_scan DUT (.*);

  always #4 clk_i = ~clk_i;

  // Predictor state: registers, counters and the superblock stack
  logic [LEN_W-1:0] frl_q, tau_q;
  logic [CNT_W-1:0] bucket_q [4];
  logic [CNT_W-1:0] position, reads_seen, open_begin, open_reads;
  logic [LEN_W-1:0] open_len;
  bit               opening, ovf_sticky;
  int               fill;
  logic [CNT_W-1:0] stk_begin [STACK_N];
  logic [CNT_W-1:0] stk_end   [STACK_N];
  logic [LEN_W-1:0] stk_len   [STACK_N];
  logic [CNT_W-1:0] stk_reads [STACK_N];

  result_t pending_arcs[$];
  int errors = 0, records_sent = 0, arcs_checked = 0, burst_left = 0;
  int unsigned cycles = 0;

  // Count leading buckets whose start lies below the position
  function automatic logic [SYM_W-1:0] lead_of(logic [CNT_W-1:0] pos);
    int s;
    s = 0;
    while (s < 4 && pos > bucket_q[s]) s++;
    return SYM_W'(s);
  endfunction

  // Pop the top entry; return 1 when it yields an arc interval
  function automatic bit pop_arc(output result_t a);
    a = '0;
    fill--;
    if (stk_reads[fill] < reads_seen) begin
      a.range_begin = stk_begin[fill];
      a.range_end   = stk_end[fill];
      a.seed_first  = stk_reads[fill];
      a.seed_count  = reads_seen - stk_reads[fill];
      a.overlap     = OVL_W'(stk_len[fill]) + OVL_W'(1);
      a.lead        = lead_of(position);
      a.overflow    = ovf_sticky;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic scan_record(input sa_rec_t r);
    result_t arcs[$];
    result_t a;
    // close the pending block when its run ends
    if (opening && (r.slen != open_len || r.lcur != open_len)) begin
      opening = 0;
      if (fill < STACK_N) begin
        stk_begin[fill] = open_begin;
        stk_end[fill]   = position;
        stk_len[fill]   = open_len;
        stk_reads[fill] = open_reads;
        fill++;
      end else begin
        ovf_sticky = 1;
      end
    end
    while (fill > 0 && stk_len[fill-1] > r.lcur)
      if (pop_arc(a)) arcs = {arcs, a};
    if ((frl_q == 0 && r.marker) || (r.slen == frl_q && position >= bucket_q[0]))
      reads_seen++;
    // rising LCP reaching tau opens a block
    if (r.lcur < r.lnext && r.lnext >= tau_q && r.slen == r.lnext) begin
      opening    = 1;
      open_begin = position;
      open_len   = r.lnext;
      open_reads = reads_seen;
    end
    if (r.is_last) begin
      while (fill > 0)
        if (pop_arc(a)) arcs = {arcs, a};
      position   = '0;
      reads_seen = '0;
      opening    = 0;
      fill       = 0;
    end else begin
      position++;
    end
    if (arcs.size() > 0) arcs[arcs.size()-1].run_last = 1'b1;
    pending_arcs = {pending_arcs, arcs};
  endtask

  // Drive one record and wait for its transfer
  task automatic send_record(input sa_rec_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i) s_axis_tvalid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {4'b0, r.lnext, r.lcur, r.slen};
    s_axis_tuser_i  = r.marker;
    s_axis_tlast_i  = r.is_last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    scan_record(r);
    records_sent++;
  endtask

  task automatic send_fields(input int sl, lc, ln, input bit mk, lst);
    sa_rec_t r;
    r.slen = LEN_W'(sl); r.lcur = LEN_W'(lc); r.lnext = LEN_W'(ln);
    r.marker = mk; r.is_last = lst;
    send_record(r);
  endtask

  // Hold until every expected result has arrived, then let the back settle
  task automatic drain_results();
    @(negedge clk_i) s_axis_tvalid_i = 1'b0;
    wait (pending_arcs.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CNT_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_addr_i  = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_FULL_READ_LEN: frl_q = val[LEN_W-1:0];
      REG_MIN_OVERLAP:   tau_q = val[LEN_W-1:0];
      REG_BUCKET_A:      bucket_q[0] = val;
      REG_BUCKET_C:      bucket_q[1] = val;
      REG_BUCKET_G:      bucket_q[2] = val;
      REG_BUCKET_T:      bucket_q[3] = val;
      default: ;
    endcase
    @(negedge clk_i) cfg_valid_i = 1'b0;
  endtask

  task automatic set_config(input int frl, tau, input logic [CNT_W-1:0] ba, bc, bg, bt);
    write_reg(REG_FULL_READ_LEN, CNT_W'(frl));
    write_reg(REG_MIN_OVERLAP, CNT_W'(tau));
    write_reg(REG_BUCKET_A, ba);
    write_reg(REG_BUCKET_C, bc);
    write_reg(REG_BUCKET_G, bg);
    write_reg(REG_BUCKET_T, bt);
  endtask

  // A well-formed stream: lcp_ahead matches the next record's lcp_here
  task automatic send_stream(input int n, lo, hi);
    int lcp [$];
    int sl, pick;
    for (int i = 0; i < n; i++) lcp = {lcp, int'($urandom_range(lo, hi))};
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 7);
      if (i + 1 < n && pick < 4) sl = lcp[i+1];
      else if (pick < 6) sl = int'(frl_q);
      else sl = $urandom_range(lo, hi + 4);
      send_fields(sl, lcp[i], (i + 1 < n) ? lcp[i+1] : 0,
                  $urandom_range(0, 2) == 0, i == n - 1);
    end
  endtask

  task automatic test_directed();
    set_config(0, 2, 32'd1, 32'd3, 32'd5, 32'd7);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    // nested blocks with markers, then the final record drains them
    send_fields(0, 0, 3, 1, 0);
    send_fields(3, 0, 3, 1, 0);
    send_fields(5, 3, 5, 1, 0);
    send_fields(5, 5, 5, 1, 0);
    send_fields(9, 5, 2, 1, 0);
    send_fields(2, 2, 0, 1, 1);
    // field extremes
    send_fields(4095, 4095, 4095, 1, 0);
    send_fields(0, 0, 0, 0, 0);
    send_fields(4095, 0, 4095, 1, 0);
    send_fields(7, 4095, 0, 1, 0);
    send_fields(4095, 4095, 4095, 0, 1);
    // block pending at the final record is closed, pushed and drained
    send_fields(5, 0, 5, 1, 0);
    send_fields(6, 0, 5, 1, 1);
    // final record on its own, with and without a marker
    send_fields(1, 1, 1, 1, 1);
    send_fields(0, 0, 0, 0, 1);
    drain_results();
    // full-length reads count only at or above the A bucket start
    set_config(10, 0, 32'd2, 32'd4, 32'd6, 32'hFFFF_FFFF);
    send_fields(10, 0, 4, 0, 0);
    send_fields(4, 0, 4, 0, 0);
    send_fields(10, 4, 4, 0, 0);
    send_fields(10, 4, 8, 1, 0);
    send_fields(8, 8, 1, 0, 0);
    send_fields(10, 1, 0, 0, 1);
    drain_results();
  endtask

  task automatic test_random_streams();
    int n;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: set_config(0, 3, 32'd2, 32'd6, 32'd10, 32'd14);
        1: set_config(12, 0, 32'd0, 32'd0, 32'd0, 32'd0);
        default: set_config(4095, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF);
      endcase
      n = 0;
      while (n < 22) begin
        if ($urandom_range(0, 9) == 0) begin
          send_fields(int'($urandom), int'($urandom), int'($urandom), 1'($urandom),
                      $urandom_range(0, 3) == 0);
          n++;
        end else if (ph == 2 && $urandom_range(0, 1)) begin
          send_fields(4095, 4094, 4095, 1, 0);
          send_fields(4095, 4095, 4095, 1'($urandom), 0);
          send_fields($urandom_range(0, 4095), $urandom_range(0, 4094), 0, 1, 1);
          n += 3;
        end else begin
          send_stream($urandom_range(3, 14), (ph == 1) ? 4 : 0, (ph == 1) ? 16 : 12);
          n += 8;
        end
      end
      drain_results();
    end
  endtask

  // Push more blocks than the stack holds, then drain
  task automatic test_stack_overflow();
    set_config(0, 0, 32'd20, 32'd40, 32'd60, 32'd80);
    for (int k = 0; k < STACK_N + 6; k++) send_fields(k + 1, k, k + 1, 1, 0);
    send_fields(0, 0, 0, 1, 1);
    send_stream(10, 0, 6);
    drain_results();
  endtask

  // Receiver stall pattern: modes of always ready, light and heavy stalls
  int stall_mode = 0, mode_left = 0;
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(10, 60);
    end
    mode_left--;
    case (stall_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic check_field(input string name, input logic [63:0] exp, act);
    if (exp !== act) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp, act);
      errors++;
    end
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_arcs.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %0h", $time, m_axis_tdata_o);
        errors++;
      end else begin
        e = pending_arcs.pop_front();
        check_field("range_begin", 64'(e.range_begin), 64'(m_axis_tdata_o[31:0]));
        check_field("range_end", 64'(e.range_end), 64'(m_axis_tdata_o[63:32]));
        check_field("seed_first", 64'(e.seed_first), 64'(m_axis_tdata_o[95:64]));
        check_field("seed_count", 64'(e.seed_count), 64'(m_axis_tdata_o[127:96]));
        check_field("overlap_len", 64'(e.overlap), 64'(m_axis_tdata_o[140:128]));
        check_field("lead_symbol", 64'(e.lead), 64'(m_axis_tdata_o[143:141]));
        check_field("overflow_seen", 64'(e.overflow), 64'(m_axis_tuser_o));
        check_field("run_last", 64'(e.run_last), 64'(m_axis_tlast_o));
        arcs_checked++;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    frl_q = '0; tau_q = '0;
    foreach (bucket_q[i]) bucket_q[i] = '0;
    position = '0; reads_seen = '0; open_begin = '0; open_reads = '0; open_len = '0;
    opening = 0; ovf_sticky = 0; fill = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    test_directed();
    test_random_streams();
    test_stack_overflow();
    if (pending_arcs.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_arcs.size());
      errors++;
    end
    $display("Sent %0d suffix records over six register settings, incl. stack overflow;",
             records_sent);
    $display("checked %0d arc intervals field by field.", arcs_checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
